[src/waypoint_distance_and_turn_unit_defines.svh]
// Assertion macros for the waypoint distance and turn unit.
// Define ASSERT_OFF to drop every check; no other dependencies.
`ifndef WAYPOINT_DISTANCE_AND_TURN_UNIT_DEFINES_SVH
`define WAYPOINT_DISTANCE_AND_TURN_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold in the same cycle as its trigger.
`define WDT_ASSERT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("waypoint unit: check failed");
// Property that must hold in the cycle after its trigger.
`define WDT_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("waypoint unit: check failed");
`else
`define WDT_ASSERT(lbl, clk, rst, pre, post)
`define WDT_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

[src/wdt_pkg.sv]
// Shared constants, arctangent table and pipeline control type for the
// waypoint distance and turn unit. No dependencies.
package wdt_pkg;

   localparam int FIELD_BITS    = 16;
   localparam int OUT_BITS      = 17;
   localparam int REQ_DATA_BITS = 80;
   localparam int RSP_DATA_BITS = 40;
   localparam int GUARD         = 24;
   localparam int TABLE_LEN     = 24;
   localparam logic [31:0] HALF_TURN_Z = 32'h8000_0000;

   // atan(2^-i) as a 32-bit binary angle, rounded to nearest
   localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic valid;
      logic null_vec;   // start and target coincide
   } wdt_ctl_type;

endpackage

[src/waypoint_distance_and_turn_unit.sv]
// Waypoint distance and turn unit: rounded Euclidean distance and shortest
// signed turn toward a target cell, one transaction per clock while the output is not stalled.
// Pipeline from input acceptance to result valid: three front stages, one
// stage per CORDIC / square-root digit step, two finishing stages.
// Throughput: one transaction per cycle; every stage advances together when
// the result register is empty or being taken. Reset clears all valid bits.
module waypoint_distance_and_turn_unit #(
   parameter int COORD_BITS   = 16,
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // from_x, from_y, to_x, to_y, heading (16 bits each, lowest first)
   input  logic [wdt_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // distance (17 bits), turn_offset (17 bits, signed), 6 zero bits
   output logic [wdt_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);

   localparam int CW = (COORD_BITS < wdt_pkg::FIELD_BITS) ? COORD_BITS : wdt_pkg::FIELD_BITS;
   localparam int RB = CW + 1;
   localparam int NB = 2 * RB;
   localparam int W  = CW + wdt_pkg::GUARD + 3;
   localparam int CS = (CORDIC_STEPS < wdt_pkg::TABLE_LEN) ? CORDIC_STEPS : wdt_pkg::TABLE_LEN;
   localparam int K  = (CS > RB) ? CS : RB;
   localparam int AB = ANGLE_BITS;

   logic                                adv;
   logic signed [W-1:0]                 x_s    [K+1];
   logic signed [W-1:0]                 y_s    [K+1];
   logic [31:0]                         z_s    [K+1];
   logic [RB-1:0]                       root_s [K+1];
   logic [RB+1:0]                       rem_s  [K+1];
   logic [NB-1:0]                       n_s    [K+1];
   logic [AB-1:0]                       head_s [K+1];
   wdt_pkg::wdt_ctl_type                ctl_s  [K+1];
   logic [wdt_pkg::OUT_BITS-1:0]        distance, turn_offset;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   wdt_front #(
      .CW (CW),
      .AB (AB),
      .W  (W)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .accept  (req_tvalid && req_tready),
      .from_x  (req_tdata[15:0]),
      .from_y  (req_tdata[31:16]),
      .to_x    (req_tdata[47:32]),
      .to_y    (req_tdata[63:48]),
      .heading (req_tdata[79:64]),
      .x_o     (x_s[0]),
      .y_o     (y_s[0]),
      .z_o     (z_s[0]),
      .n_o     (n_s[0]),
      .head_o  (head_s[0]),
      .ctl_o   (ctl_s[0])
   );

   assign root_s[0] = '0;
   assign rem_s[0]  = '0;

   for (genvar j = 0; j < K; j++) begin : g_stage
      wdt_iter_stage #(
         .W     (W),
         .RB    (RB),
         .AB    (AB),
         .IDX   (j),
         .STEPS (CS)
      ) u_iter (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .x_i    (x_s[j]),
         .y_i    (y_s[j]),
         .z_i    (z_s[j]),
         .root_i (root_s[j]),
         .rem_i  (rem_s[j]),
         .n_i    (n_s[j]),
         .head_i (head_s[j]),
         .ctl_i  (ctl_s[j]),
         .x_o    (x_s[j+1]),
         .y_o    (y_s[j+1]),
         .z_o    (z_s[j+1]),
         .root_o (root_s[j+1]),
         .rem_o  (rem_s[j+1]),
         .n_o    (n_s[j+1]),
         .head_o (head_s[j+1]),
         .ctl_o  (ctl_s[j+1])
      );
   end

   wdt_finish #(
      .RB (RB),
      .AB (AB)
   ) u_finish (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .z_i           (z_s[K]),
      .root_i        (root_s[K]),
      .rem_i         (rem_s[K]),
      .head_i        (head_s[K]),
      .ctl_i         (ctl_s[K]),
      .valid_o       (rsp_tvalid),
      .distance_o    (distance),
      .turn_offset_o (turn_offset)
   );

   assign rsp_tdata = {6'b000000, turn_offset, distance};

endmodule

[src/wdt_front.sv]
// Front stages: coordinate deltas, squares, half-turn prerotation of the
// bearing vector and the squared distance. Depends on wdt_pkg.
`include "waypoint_distance_and_turn_unit_defines.svh"

module wdt_front #(
   parameter int CW = 16,
   parameter int AB = 16,
   parameter int W  = 43
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                accept,
   input  logic [wdt_pkg::FIELD_BITS-1:0]      from_x,
   input  logic [wdt_pkg::FIELD_BITS-1:0]      from_y,
   input  logic [wdt_pkg::FIELD_BITS-1:0]      to_x,
   input  logic [wdt_pkg::FIELD_BITS-1:0]      to_y,
   input  logic [wdt_pkg::FIELD_BITS-1:0]      heading,
   output logic signed [W-1:0]                 x_o,
   output logic signed [W-1:0]                 y_o,
   output logic [31:0]                         z_o,
   output logic [2*CW+1:0]                     n_o,
   output logic [AB-1:0]                       head_o,
   output wdt_pkg::wdt_ctl_type                ctl_o
);

   localparam int NB = 2 * CW + 2;

   logic [CW-1:0]           fx, fy, tx, ty;
   logic signed [CW:0]      dx_in, dy_in;
   logic signed [CW:0]      dx_a_ff, dy_a_ff;
   logic [AB-1:0]           head_a_ff;
   wdt_pkg::wdt_ctl_type    ctl_a_ff;

   logic signed [2*CW+1:0]  prod_x, prod_y;
   logic signed [W-1:0]     ext_x, ext_y, x_b_in, y_b_in;
   logic [31:0]             z_b_in;
   logic [2*CW-1:0]         sq_x_ff, sq_y_ff;
   logic signed [W-1:0]     x_b_ff, y_b_ff;
   logic [31:0]             z_b_ff;
   logic [AB-1:0]           head_b_ff;
   wdt_pkg::wdt_ctl_type    ctl_b_ff;

   logic signed [W-1:0]     x_c_ff, y_c_ff;
   logic [31:0]             z_c_ff;
   logic [NB-1:0]           n_c_ff;
   logic [AB-1:0]           head_c_ff;
   wdt_pkg::wdt_ctl_type    ctl_c_ff;

   assign fx    = CW'(from_x);
   assign fy    = CW'(from_y);
   assign tx    = CW'(to_x);
   assign ty    = CW'(to_y);
   assign dx_in = $signed({1'b0, tx}) - $signed({1'b0, fx});
   assign dy_in = $signed({1'b0, ty}) - $signed({1'b0, fy});

   assign prod_x = dx_a_ff * dx_a_ff;
   assign prod_y = dy_a_ff * dy_a_ff;

   // vector is (dx, -dy) since rows grow downward; fold the left half plane
   always_comb begin
      ext_x = W'(dx_a_ff);
      ext_y = W'(dy_a_ff);
      if (dx_a_ff < 0) begin
         x_b_in = (-ext_x) <<< wdt_pkg::GUARD;
         y_b_in = ext_y <<< wdt_pkg::GUARD;
         z_b_in = wdt_pkg::HALF_TURN_Z;
      end else begin
         x_b_in = ext_x <<< wdt_pkg::GUARD;
         y_b_in = (-ext_y) <<< wdt_pkg::GUARD;
         z_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else if (adv) begin
         ctl_a_ff.valid    <= accept;
         ctl_a_ff.null_vec <= 1'b0;
         ctl_b_ff.valid    <= ctl_a_ff.valid;
         ctl_b_ff.null_vec <= (dx_a_ff == 0) && (dy_a_ff == 0);
         ctl_c_ff          <= ctl_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_a_ff   <= dx_in;
         dy_a_ff   <= dy_in;
         head_a_ff <= AB'(heading);
         sq_x_ff   <= prod_x[2*CW-1:0];
         sq_y_ff   <= prod_y[2*CW-1:0];
         x_b_ff    <= x_b_in;
         y_b_ff    <= y_b_in;
         z_b_ff    <= z_b_in;
         head_b_ff <= head_a_ff;
         x_c_ff    <= x_b_ff;
         y_c_ff    <= y_b_ff;
         z_c_ff    <= z_b_ff;
         n_c_ff    <= NB'(sq_x_ff) + NB'(sq_y_ff);
         head_c_ff <= head_b_ff;
      end
   end

   assign x_o    = x_c_ff;
   assign y_o    = y_c_ff;
   assign z_o    = z_c_ff;
   assign n_o    = n_c_ff;
   assign head_o = head_c_ff;
   assign ctl_o  = ctl_c_ff;

   `WDT_ASSERT(a_null_vector_zero, clock, reset, ctl_b_ff.valid && ctl_b_ff.null_vec, x_b_ff == 0 && y_b_ff == 0)

endmodule

[src/wdt_iter_stage.sv]
// One pipeline stage: a CORDIC vectoring step (while IDX < STEPS) and a square-root digit step (while IDX < RB).
// Depends on wdt_pkg.
`include "waypoint_distance_and_turn_unit_defines.svh"

module wdt_iter_stage #(
   parameter int W     = 43,
   parameter int RB    = 17,
   parameter int AB    = 16,
   parameter int IDX   = 0,
   parameter int STEPS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic signed [W-1:0]        x_i,
   input  logic signed [W-1:0]        y_i,
   input  logic [31:0]                z_i,
   input  logic [RB-1:0]              root_i,
   input  logic [RB+1:0]              rem_i,
   input  logic [2*RB-1:0]            n_i,
   input  logic [AB-1:0]              head_i,
   input  wdt_pkg::wdt_ctl_type       ctl_i,
   output logic signed [W-1:0]        x_o,
   output logic signed [W-1:0]        y_o,
   output logic [31:0]                z_o,
   output logic [RB-1:0]              root_o,
   output logic [RB+1:0]              rem_o,
   output logic [2*RB-1:0]            n_o,
   output logic [AB-1:0]              head_o,
   output wdt_pkg::wdt_ctl_type       ctl_o
);

   localparam int NB = 2 * RB;
   localparam bit DO_CORDIC = IDX < STEPS;
   localparam bit DO_SQRT   = IDX < RB;

   logic signed [W-1:0]   xs, ys, x_in, y_in, x_ff, y_ff;
   logic [31:0]           z_in, z_ff;
   logic [RB+1:0]         rem_sh, trial, rem_in, rem_ff;
   logic [RB-1:0]         root_in, root_ff;
   logic [NB-1:0]         n_in, n_ff;
   logic [AB-1:0]         head_ff;
   wdt_pkg::wdt_ctl_type  ctl_ff;

   always_comb begin
      xs      = x_i >>> IDX;
      ys      = y_i >>> IDX;
      rem_sh  = {rem_i[RB-1:0], n_i[NB-1 -: 2]};
      trial   = {root_i, 2'b01};
      x_in    = x_i;
      y_in    = y_i;
      z_in    = z_i;
      root_in = root_i;
      rem_in  = rem_i;
      n_in    = n_i;
      if (DO_CORDIC) begin
         // rotate toward the x axis
         if (y_i > 0) begin
            x_in = x_i + ys;
            y_in = y_i - xs;
            z_in = z_i + wdt_pkg::ATAN_TURNS[IDX];
         end else begin
            x_in = x_i - ys;
            y_in = y_i + xs;
            z_in = z_i - wdt_pkg::ATAN_TURNS[IDX];
         end
      end
      if (DO_SQRT) begin
         n_in = {n_i[NB-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_i[RB-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_i[RB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
         n_ff    <= n_in;
         head_ff <= head_i;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign root_o = root_ff;
   assign rem_o  = rem_ff;
   assign n_o    = n_ff;
   assign head_o = head_ff;
   assign ctl_o  = ctl_ff;

   `WDT_ASSERT_NEXT(a_hold_on_stall, clock, reset, !adv, $stable(ctl_ff) && $stable(root_ff) && $stable(z_ff))

endmodule

[src/wdt_finish.sv]
// Final stages: bearing rounding, distance rounding, shortest turn and the
// result register. Depends on wdt_pkg.
`include "waypoint_distance_and_turn_unit_defines.svh"

module wdt_finish #(
   parameter int RB = 17,
   parameter int AB = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic [31:0]                       z_i,
   input  logic [RB-1:0]                     root_i,
   input  logic [RB+1:0]                     rem_i,
   input  logic [AB-1:0]                     head_i,
   input  wdt_pkg::wdt_ctl_type              ctl_i,
   output logic                              valid_o,
   output logic [wdt_pkg::OUT_BITS-1:0]      distance_o,
   output logic [wdt_pkg::OUT_BITS-1:0]      turn_offset_o
);

   localparam int TW = AB + 1;
   localparam logic [31:0] HALF_LSB = 32'(1) << (31 - AB);
   localparam logic signed [TW-1:0] HALF_TURN = {2'b01, {(AB - 1){1'b0}}};

   logic [31:0]                       bear_sum;
   logic [AB-1:0]                     bear_in, bear_ff, head_ff;
   logic [RB:0]                       dist_in, dist_ff;
   wdt_pkg::wdt_ctl_type              ctl_ff;
   logic [AB-1:0]                     right, left;
   logic signed [TW-1:0]              turn_full;
   logic                              valid_ff;
   logic [wdt_pkg::OUT_BITS-1:0]      distance_ff, turn_ff;

   always_comb begin
      bear_sum = z_i + HALF_LSB;
      bear_in  = ctl_i.null_vec ? '0 : bear_sum[31 -: AB];
      // round up when n exceeds root^2 + root
      dist_in  = (RB + 1)'(root_i) + (RB + 1)'(rem_i > (RB + 2)'(root_i));
   end

   always_comb begin
      right = head_ff - bear_ff;
      left  = bear_ff - head_ff;
      if (right < left) begin
         turn_full = -$signed({1'b0, right});
      end else begin
         turn_full = $signed({1'b0, left});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         valid_ff <= 1'b0;
      end else if (adv) begin
         ctl_ff   <= ctl_i;
         valid_ff <= ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bear_ff     <= bear_in;
         head_ff     <= head_i;
         dist_ff     <= dist_in;
         distance_ff <= wdt_pkg::OUT_BITS'(dist_ff);
         turn_ff     <= wdt_pkg::OUT_BITS'(turn_full);
      end
   end

   assign valid_o       = valid_ff;
   assign distance_o    = distance_ff;
   assign turn_offset_o = turn_ff;

   `WDT_ASSERT(a_turn_in_range, clock, reset, ctl_ff.valid, turn_full <= HALF_TURN && turn_full > -HALF_TURN)
   `WDT_ASSERT(a_null_distance, clock, reset, ctl_ff.valid && ctl_ff.null_vec, dist_ff == '0)

endmodule
